// File: hw/rtl/brn_pkg.sv
// Shared types, constants and numeral tables for the binary to Roman numeral converter.
package brn_pkg;

  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned RemWidth    = 12;
  localparam int unsigned SymWidth    = 7;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned NumSym      = 13;
  localparam int unsigned IdxWidth    = 4;

  localparam logic [ValueWidth-1:0] MaxRoman = 16'd3999;

  localparam logic [SymWidth-1:0] ChM    = 7'h4D;
  localparam logic [SymWidth-1:0] ChD    = 7'h44;
  localparam logic [SymWidth-1:0] ChC    = 7'h43;
  localparam logic [SymWidth-1:0] ChL    = 7'h4C;
  localparam logic [SymWidth-1:0] ChX    = 7'h58;
  localparam logic [SymWidth-1:0] ChV    = 7'h56;
  localparam logic [SymWidth-1:0] ChI    = 7'h49;
  localparam logic [SymWidth-1:0] ChNone = 7'h00;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk    = 2'd0,
    StatusZero  = 2'd1,
    StatusRange = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic special;
    logic step_last;
  } dp_stat_t;

  // Greedy table, largest first; subtractive forms are two-letter entries.
  function automatic logic [RemWidth-1:0] sym_value(input logic [IdxWidth-1:0] idx);
    logic [RemWidth-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      4'd12:   v = 12'd1;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic logic [SymWidth-1:0] sym_first(input logic [IdxWidth-1:0] idx);
    logic [SymWidth-1:0] c;
    case (idx)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      4'd11:   c = ChI;
      4'd12:   c = ChI;
      default: c = ChNone;
    endcase
    return c;
  endfunction

  function automatic logic [SymWidth-1:0] sym_second(input logic [IdxWidth-1:0] idx);
    logic [SymWidth-1:0] c;
    case (idx)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChNone;
    endcase
    return c;
  endfunction

  function automatic logic sym_pair(input logic [IdxWidth-1:0] idx);
    return idx[0] && (idx != 4'd13) && (idx < 4'd12);
  endfunction

endpackage

// File: hw/rtl/brn_value_if.sv
// Input channel carrying one binary number per word.
interface brn_value_if;
  logic                             valid;
  logic                             ready;
  logic [brn_pkg::ValueWidth-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: hw/rtl/brn_symbol_if.sv
// Output channel carrying one numeral character per word.
interface brn_symbol_if;
  logic                              valid;
  logic                              ready;
  logic [brn_pkg::SymWidth-1:0]      symbol;
  logic                              last;
  logic [brn_pkg::StatusWidth-1:0]   status;

  modport source (output valid, output symbol, output last, output status, input ready);
  modport sink   (input valid, input symbol, input last, input status, output ready);
endinterface

// File: hw/rtl/binary_to_roman_numeral_core.sv
// Top level of the binary to Roman numeral converter.
// The accepted word is loaded into the remainder register; the controller then steps, and each step
// registers one character into the output register, one per cycle while the output is not held off.
// After the last character the controller returns to idle and takes the next word once the output is free.
// Zero and out-of-range values give one word and leave the controller idle, ready once the output is free.
// Reset is asynchronous and active low; it empties the output register and returns to idle.
module binary_to_roman_numeral_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  brn_value_if.sink    in_i,
  brn_symbol_if.source out_o
);

  brn_pkg::dp_cmd_t  cmd;
  brn_pkg::dp_stat_t stat;

  brn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  brn_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_i     (in_i.value),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .symbol_o    (out_o.symbol),
    .last_o      (out_o.last),
    .status_o    (out_o.status)
  );

  // A word with a zero or range status is always a lone, final word with no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != brn_pkg::StatusOk)) |->
      (out_o.last && (out_o.symbol == brn_pkg::ChNone)))
    else $error("special result carries a character or is not final");

  // Every ordinary word carries one of the seven numeral letters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == brn_pkg::StatusOk)) |->
      ((out_o.symbol == brn_pkg::ChM) || (out_o.symbol == brn_pkg::ChD) ||
       (out_o.symbol == brn_pkg::ChC) || (out_o.symbol == brn_pkg::ChL) ||
       (out_o.symbol == brn_pkg::ChX) || (out_o.symbol == brn_pkg::ChV) ||
       (out_o.symbol == brn_pkg::ChI)))
    else $error("ordinary result is not a numeral letter");

  // An accepted zero value is answered in the next cycle with the empty-numeral status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.value == '0)) |=>
      (out_o.valid && (out_o.status == brn_pkg::StatusZero)))
    else $error("zero value not answered with empty status");

endmodule

// File: hw/rtl/brn_datapath.sv
// Remainder register, greedy numeral table search and output register.
module brn_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  brn_pkg::dp_cmd_t                cmd_i,
  output brn_pkg::dp_stat_t               stat_o,
  input  logic [brn_pkg::ValueWidth-1:0]  value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [brn_pkg::SymWidth-1:0]    symbol_o,
  output logic                            last_o,
  output logic [brn_pkg::StatusWidth-1:0] status_o
);

  logic [brn_pkg::RemWidth-1:0]    rem_q, rem_d;
  logic                            pend_q, pend_d;
  logic [brn_pkg::SymWidth-1:0]    pend_char_q, pend_char_d;
  logic                            out_valid_q, out_valid_d;
  logic [brn_pkg::SymWidth-1:0]    out_sym_q;
  logic                            out_last_q;
  logic [brn_pkg::StatusWidth-1:0] out_status_q;

  logic [brn_pkg::IdxWidth-1:0]    sel;
  logic [brn_pkg::RemWidth-1:0]    rem_sub;
  logic [brn_pkg::SymWidth-1:0]    step_sym;
  logic                            step_last;
  logic                            is_zero;
  logic                            is_range;
  logic                            out_free;

  assign is_zero  = (value_i == '0);
  assign is_range = (value_i > brn_pkg::MaxRoman);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sel = '0;
    for (int i = brn_pkg::NumSym - 1; i >= 0; i--) begin
      if (rem_q >= brn_pkg::sym_value(brn_pkg::IdxWidth'(i))) begin
        sel = brn_pkg::IdxWidth'(i);
      end
    end
    rem_sub = rem_q - brn_pkg::sym_value(sel);

    if (pend_q) begin
      step_sym    = pend_char_q;
      step_last   = (rem_q == '0);
      rem_d       = rem_q;
      pend_d      = 1'b0;
      pend_char_d = pend_char_q;
    end else begin
      step_sym    = brn_pkg::sym_first(sel);
      rem_d       = rem_sub;
      pend_d      = brn_pkg::sym_pair(sel);
      pend_char_d = brn_pkg::sym_second(sel);
      step_last   = !brn_pkg::sym_pair(sel) && (rem_sub == '0);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((cmd_i.load && (is_zero || is_range)) || cmd_i.step) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.load) begin
        pend_q <= 1'b0;
      end else if (cmd_i.step) begin
        pend_q <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i[brn_pkg::RemWidth-1:0];
      if (is_zero) begin
        out_sym_q    <= brn_pkg::ChNone;
        out_last_q   <= 1'b1;
        out_status_q <= brn_pkg::StatusZero;
      end else if (is_range) begin
        out_sym_q    <= brn_pkg::ChNone;
        out_last_q   <= 1'b1;
        out_status_q <= brn_pkg::StatusRange;
      end
    end else if (cmd_i.step) begin
      rem_q        <= rem_d;
      pend_char_q  <= pend_char_d;
      out_sym_q    <= step_sym;
      out_last_q   <= step_last;
      out_status_q <= brn_pkg::StatusOk;
    end
  end

  assign stat_o.out_free  = out_free;
  assign stat_o.special   = is_zero || is_range;
  assign stat_o.step_last = step_last;

  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign last_o      = out_last_q;
  assign status_o    = out_status_q;

endmodule

// File: hw/rtl/brn_ctrl.sv
// Controller state machine that sequences one number's conversion.
module brn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brn_pkg::dp_stat_t stat_i,
  output brn_pkg::dp_cmd_t  cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StConv = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = stat_i.out_free;
        cmd_o.load = in_valid_i && stat_i.out_free;
        if (cmd_o.load && !stat_i.special) begin
          state_d = StConv;
        end
      end
      StConv: begin
        cmd_o.step = stat_i.out_free;
        if (cmd_o.step && stat_i.step_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: test/binary_to_roman_numeral_checker.sv
// Checker for the Roman numeral converter: predicts each numeral and compares the output words.
module binary_to_roman_numeral_checker
  import brn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  brn_value_if        value_ch,
  brn_symbol_if       symbol_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [SymWidth-1:0] symbol;
    logic                last;
    status_e             status;
  } numeral_word_t;

  numeral_word_t numeral_q[$];
  int unsigned   fails   = 0;
  int unsigned   pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic queue_numeral(input logic [ValueWidth-1:0] value);
    logic [SymWidth-1:0] letters[$];
    logic [SymWidth-1:0] unit_ch[3];
    logic [SymWidth-1:0] five_ch[3];
    logic [SymWidth-1:0] ten_ch[3];
    int unsigned         digit[3];
    int unsigned         d;
    numeral_word_t       w;
    unit_ch = '{ChC, ChX, ChI};
    five_ch = '{ChD, ChL, ChV};
    ten_ch  = '{ChM, ChC, ChX};
    if (value == '0) begin
      w = '{ChNone, 1'b1, StatusZero};
      numeral_q.push_back(w);
      return;
    end
    if (value > MaxRoman) begin
      w = '{ChNone, 1'b1, StatusRange};
      numeral_q.push_back(w);
      return;
    end
    repeat (value / 1000) letters.push_back(ChM);
    digit[0] = (value / 100) % 10;
    digit[1] = (value / 10) % 10;
    digit[2] = value % 10;
    for (int p = 0; p < 3; p++) begin
      d = digit[p];
      if (d == 9) begin
        letters.push_back(unit_ch[p]);
        letters.push_back(ten_ch[p]);
      end else if (d == 4) begin
        letters.push_back(unit_ch[p]);
        letters.push_back(five_ch[p]);
      end else begin
        if (d >= 5) begin
          letters.push_back(five_ch[p]);
          d = d - 5;
        end
        repeat (d) letters.push_back(unit_ch[p]);
      end
    end
    foreach (letters[k]) begin
      w.symbol = letters[k];
      w.last   = (k == letters.size() - 1);
      w.status = StatusOk;
      numeral_q.push_back(w);
    end
  endtask

  always @(posedge clk_i) begin : watch
    numeral_word_t want;
    if (rst_ni) begin
      if (value_ch.valid && value_ch.ready) begin
        queue_numeral(value_ch.value);
      end
      if (symbol_ch.valid && symbol_ch.ready) begin
        if (numeral_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, expected none, got symbol=%h last=%b status=%0d",
                   $time, symbol_ch.symbol, symbol_ch.last, symbol_ch.status);
        end else begin
          want = numeral_q.pop_front();
          if (want.symbol !== symbol_ch.symbol || want.last !== symbol_ch.last ||
              want.status !== symbol_ch.status) begin
            fails++;
            $display("%0t: expected symbol=%h last=%b status=%0d, got symbol=%h last=%b status=%0d",
                     $time, want.symbol, want.last, want.status,
                     symbol_ch.symbol, symbol_ch.last, symbol_ch.status);
          end
        end
      end
      pending = numeral_q.size();
    end
  end

endmodule

// File: test/binary_to_roman_numeral_core_tb.sv
// Testbench top for the Roman numeral converter: clock, reset, stimulus, flow control and verdict.
module binary_to_roman_numeral_core_tb;
  import brn_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned BurstItems  = 8;
  localparam int unsigned RandomItems = 200;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  bit          rx_hold_req  = 1'b0;

  brn_value_if  in_ch();
  brn_symbol_if out_ch();

  always #4 clk_i = ~clk_i;

  binary_to_roman_numeral_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  binary_to_roman_numeral_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_ch     (in_ch),
    .symbol_ch    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [ValueWidth-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 16) return ValueWidth'($urandom_range(4000, 65535));
    if (pick < 40) return ValueWidth'($urandom_range(1, 99));
    return ValueWidth'($urandom_range(1, 3999));
  endfunction

  task automatic send_value(input logic [ValueWidth-1:0] value);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [ValueWidth-1:0] directed[$];
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    directed = '{16'd0, 16'd1, 16'd3999, 16'd4000, 16'd65535, 16'd3888, 16'd4, 16'd9,
                 16'd40, 16'd90, 16'd400, 16'd900, 16'd1994, 16'd2444, 16'd5, 16'd10,
                 16'd50, 16'd100, 16'd500, 16'd1000, 16'd3000, 16'd49, 16'd3449,
                 16'h8000};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[k]) send_value(directed[k]);
    wait_drained();
    // Output held off while words keep coming, so the converter backs up into its input.
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (BurstItems) send_value(random_value());
    tx_idle_on = 1'b1;
    for (int k = 0; k < RandomItems; k++) begin
      if (k % 40 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
      send_value(random_value());
    end
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned words;
    words        = 0;
    out_ch.ready = 1'b0;
    @(negedge clk_i);
    while (!rst_ni) @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (words % 40 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      stall = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      words++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
